// ===== rtl/core/lst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lst_pkg
// Types and constants shared by the LCD scanline and mode timing block.
// ----------------------------------------------------------------------------
package lst_pkg;

  // Item kinds carried in the mode field of an input transaction.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } item_kind_t;

  // Register select codes.
  typedef enum logic [1:0] {
    REG_LCDC = 2'd0,
    REG_STAT = 2'd1,
    REG_LY   = 2'd2,
    REG_LYC  = 2'd3
  } reg_sel_t;

  // Display modes as seen in STAT bits 1:0.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Line timing.
  localparam logic [9:0] LINE_CLOCKS = 10'd456;
  localparam logic [8:0] MAX_TICK    = 9'd455;
  localparam logic [7:0] LAST_LINE   = 8'd153;
  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [8:0] OAM_END     = 9'd80;
  localparam logic [8:0] XFER_END    = 9'd252;

  // STAT and LCDC bit positions.
  localparam int LCDC_ENABLE_BIT = 7;
  localparam int STAT_BUSY_BIT   = 7;
  localparam int STAT_LYC_IE_BIT = 6;
  localparam int STAT_OAM_IE_BIT = 5;
  localparam int STAT_VBL_IE_BIT = 4;
  localparam int STAT_HBL_IE_BIT = 3;
  localparam int STAT_COIN_BIT   = 2;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
    logic [8:0] cycles;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       stat_interrupt;
    logic       oam_locked;
    logic       vram_locked;
    logic [7:0] line_number;
  } result_t;

  // Handshake between the input register and the timing engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } staged_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/lcd_scanline_mode_timing.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timing
// LCD line, mode and STAT interrupt timing with a small register file.
// ----------------------------------------------------------------------------
// This block takes one transaction per clock on the item channel while the
// result channel keeps taking results, and returns exactly one result
// transaction for each, in order. A transaction is either a tick that
// advances the line dot counter (456 dots per line) by up to 455 dots, a
// write of LCDC, STAT or LYC (LY is read-only), or a read of one of the four
// registers. The result carries the read byte, the STAT interrupt request of
// a tick, the sprite and video memory lock flags and the current line. The
// sustained rate is one transaction per cycle while results are taken. The
// accepted transaction sits in the input register while the whole update is
// done in one combinational pass, and the result register takes the outcome
// when it is empty or being drained. Result backpressure stalls the input
// register, which still accepts a transaction while the result waits if empty.
module lcd_scanline_mode_timing
  import lst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output      logic    item_ready,
  input  wire item_t   item,
  output      logic    result_valid,
  input  wire logic    result_ready,
  output      result_t result
);

  staged_item_t staged;
  result_t      result_next;
  logic         advance;

  // The engine consumes the staged transaction whenever the result register
  // is empty or is being drained in this cycle.
  assign advance = staged.valid && (!result_valid || result_ready);

  lst_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .advance    (advance),
    .staged     (staged)
  );

  // The engine holds all timing state and updates it only on advance.
  lst_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (staged.item),
    .result_next (result_next)
  );

  // Result register: loaded on advance, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lst_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lst_in_reg
// Input register: holds one accepted transaction until the engine takes it.
// ----------------------------------------------------------------------------
module lst_in_reg
  import lst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output      logic         item_ready,
  input  wire item_t        item,
  input  wire logic         advance,
  output      staged_item_t staged
);

  logic  valid_q;
  item_t item_q;

  assign item_ready = !valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (item_ready) begin
      valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  assign staged.valid = valid_q;
  assign staged.item  = item_q;

endmodule
`default_nettype wire

// ===== rtl/core/lst_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lst_engine
// Timing state and register file with the single-pass update for one item.
// ----------------------------------------------------------------------------
module lst_engine
  import lst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  wire item_t   item,
  output      result_t result_next
);

  logic [8:0] dot_counter, dot_counter_next;
  logic [7:0] current_line, current_line_next;
  logic [7:0] line_compare, line_compare_next;
  logic [7:0] lcd_control, lcd_control_next;
  logic [7:0] lcd_status, lcd_status_next;
  logic       oam_lock, oam_lock_next;
  logic       vram_lock, vram_lock_next;

  logic [8:0] cyc;
  logic [9:0] sum;
  logic       wrap;
  logic [7:0] stat;
  logic [1:0] prev_mode;
  logic [1:0] new_mode;
  logic       irq;
  logic [7:0] rd;
  logic [9:0] dot_wrapped;

  always_comb begin
    dot_counter_next  = dot_counter;
    current_line_next = current_line;
    line_compare_next = line_compare;
    lcd_control_next  = lcd_control;
    lcd_status_next   = lcd_status;
    oam_lock_next     = oam_lock;
    vram_lock_next    = vram_lock;
    irq               = 1'b0;
    rd                = 8'd0;
    stat              = lcd_status;
    prev_mode         = lcd_status[1:0];
    new_mode          = MODE_HBLANK;
    cyc               = (item.cycles > MAX_TICK) ? MAX_TICK : item.cycles;
    sum               = {1'b0, dot_counter} + {1'b0, cyc};
    wrap              = (sum >= LINE_CLOCKS);
    dot_wrapped       = sum - LINE_CLOCKS;

    case (item_kind_t'(item.mode))
      KIND_TICK: begin
        if (!lcd_control[LCDC_ENABLE_BIT]) begin
          dot_counter_next  = '0;
          current_line_next = '0;
          lcd_status_next   = {1'b1, lcd_status[6:3], 3'b000};
        end else begin
          dot_counter_next = wrap ? dot_wrapped[8:0] : sum[8:0];
          if (wrap) begin
            current_line_next = (current_line == LAST_LINE) ? 8'd0 : current_line + 8'd1;
            stat[STAT_COIN_BIT] = (current_line_next == line_compare);
            if (stat[STAT_COIN_BIT] && stat[STAT_LYC_IE_BIT]) begin
              irq = 1'b1;
            end
          end
          if (current_line_next >= VBLANK_LINE) begin
            new_mode = MODE_VBLANK;
            if (prev_mode != MODE_VBLANK && stat[STAT_VBL_IE_BIT]) begin
              irq = 1'b1;
            end
          end else if (dot_counter_next < OAM_END) begin
            new_mode      = MODE_OAM;
            oam_lock_next = 1'b1;
            if (prev_mode != MODE_OAM && stat[STAT_OAM_IE_BIT]) begin
              irq = 1'b1;
            end
          end else if (dot_counter_next < XFER_END) begin
            new_mode       = MODE_XFER;
            vram_lock_next = 1'b1;
          end else begin
            new_mode       = MODE_HBLANK;
            oam_lock_next  = 1'b0;
            vram_lock_next = 1'b0;
            if (prev_mode != MODE_HBLANK && stat[STAT_HBL_IE_BIT]) begin
              irq = 1'b1;
            end
          end
          lcd_status_next = {1'b1, stat[6:2], new_mode};
        end
      end
      KIND_WRITE: begin
        case (reg_sel_t'(item.reg_sel))
          REG_LCDC: lcd_control_next = item.write_data;
          REG_STAT: lcd_status_next  = {1'b1, item.write_data[6:3], lcd_status[2:0]};
          REG_LY:   ;
          REG_LYC:  line_compare_next = item.write_data;
          default:  ;
        endcase
      end
      KIND_READ: begin
        case (reg_sel_t'(item.reg_sel))
          REG_LCDC: rd = lcd_control;
          REG_STAT: rd = lcd_status;
          REG_LY:   rd = current_line;
          REG_LYC:  rd = line_compare;
          default:  rd = 8'd0;
        endcase
      end
      default: ;
    endcase

    result_next.read_data      = rd;
    result_next.stat_interrupt = irq;
    result_next.oam_locked     = oam_lock_next;
    result_next.vram_locked    = vram_lock_next;
    result_next.line_number    = current_line_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_counter  <= '0;
      current_line <= '0;
      line_compare <= '0;
      lcd_control  <= '0;
      lcd_status   <= '0;
      oam_lock     <= 1'b0;
      vram_lock    <= 1'b0;
    end else if (advance) begin
      dot_counter  <= dot_counter_next;
      current_line <= current_line_next;
      line_compare <= line_compare_next;
      lcd_control  <= lcd_control_next;
      lcd_status   <= lcd_status_next;
      oam_lock     <= oam_lock_next;
      vram_lock    <= vram_lock_next;
    end
  end

`ifndef SYNTH
  // The line clock position never reaches a full line.
  a_dot_in_range: assert property (@(posedge clk) disable iff (rst)
    dot_counter < LINE_CLOCKS[8:0])
    else $error("dot counter left the line");

  // The line number stays within the frame.
  a_line_in_range: assert property (@(posedge clk) disable iff (rst)
    current_line <= LAST_LINE)
    else $error("line number beyond last line");

  // Only a tick can raise the STAT interrupt.
  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (advance && result_next.stat_interrupt) |-> (item.mode == KIND_TICK))
    else $error("interrupt raised by a bus transaction");

  // After any tick the busy bit of STAT is set.
  a_tick_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (advance && item.mode == KIND_TICK) |=> lcd_status[STAT_BUSY_BIT])
    else $error("STAT bit 7 not set after tick");

  // With the display off, a tick leaves the counter and line cleared.
  a_off_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && item.mode == KIND_TICK && !lcd_control[LCDC_ENABLE_BIT])
      |=> (dot_counter == 9'd0 && current_line == 8'd0))
    else $error("display off did not clear timing");
`endif

endmodule
`default_nettype wire

// ===== tb/lcd_scanline_mode_timing_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timing_test
// Self-checking bench for the LCD line, mode and STAT interrupt timing block.
// The bench drives tick, register write, register read and unused-kind
// transactions through the item channel. An in-bench model of the line
// counter and register file predicts each result. Every result transaction
// is compared field by field against that prediction, or against the given
// result of a typed directed row. Both channels idle at random in the first
// two phases. One long result hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timing_test;
  import lst_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 4;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;

  // The item kind field is two bits wide, and its fourth code is not used.
  // The block must treat it as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  // A result with every field zero: a bus item before the display runs.
  localparam result_t QUIET = '0;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  always #(CLK_PERIOD / 2) clk = ~clk;

  lcd_scanline_mode_timing u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // --------------------------------------------------------------------------
  // Display timing model. These registers mirror the block's state. They are
  // advanced once for every transaction that the item channel accepts.
  // --------------------------------------------------------------------------
  logic [8:0] model_dots;
  logic [7:0] model_ly;
  logic [7:0] model_lyc;
  logic [7:0] model_lcdc;
  logic [7:0] model_stat;
  logic       model_oam_lock;
  logic       model_vram_lock;

  // Activity counters for the closing summary.
  int ticks_run;
  int lines_wrapped;
  int frames_done;
  int irqs_raised;
  int display_offs;

  function automatic result_t next_display_result(input item_t it);
    result_t    r;
    logic [9:0] dots_sum;
    logic [8:0] step;
    logic [7:0] stat;
    logic [1:0] prev_mode;
    logic       irq;
    r   = '0;
    irq = 1'b0;
    case (it.mode)
      KIND_TICK: begin
        ticks_run++;
        stat      = model_stat;
        prev_mode = stat[1:0];
        if (!model_lcdc[LCDC_ENABLE_BIT]) begin
          // With the display off, the tick parks the counter and the line and sets the busy bit.
          // The mode and coincidence bits are cleared, and the locks stay as they were.
          display_offs++;
          model_dots = '0;
          model_ly   = '0;
          model_stat = {1'b1, stat[6:3], 3'b000};
        end else begin
          step     = (it.cycles > MAX_TICK) ? MAX_TICK : it.cycles;
          dots_sum = model_dots + step;
          if (dots_sum >= LINE_CLOCKS) begin
            dots_sum = dots_sum - LINE_CLOCKS;
            lines_wrapped++;
            if (model_ly == LAST_LINE) begin
              model_ly = '0;
              frames_done++;
            end else begin
              model_ly = model_ly + 8'd1;
            end
            // The coincidence flag is only re-evaluated when a line wraps.
            if (model_ly == model_lyc) begin
              stat[STAT_COIN_BIT] = 1'b1;
              if (stat[STAT_LYC_IE_BIT]) irq = 1'b1;
            end else begin
              stat[STAT_COIN_BIT] = 1'b0;
            end
          end
          model_dots = dots_sum[8:0];
          if (model_ly >= VBLANK_LINE) begin
            if (prev_mode != MODE_VBLANK && stat[STAT_VBL_IE_BIT]) irq = 1'b1;
            stat[1:0] = MODE_VBLANK;
          end else if (model_dots < OAM_END) begin
            model_oam_lock = 1'b1;
            if (prev_mode != MODE_OAM && stat[STAT_OAM_IE_BIT]) irq = 1'b1;
            stat[1:0] = MODE_OAM;
          end else if (model_dots < XFER_END) begin
            model_vram_lock = 1'b1;
            stat[1:0] = MODE_XFER;
          end else begin
            model_oam_lock  = 1'b0;
            model_vram_lock = 1'b0;
            if (prev_mode != MODE_HBLANK && stat[STAT_HBL_IE_BIT]) irq = 1'b1;
            stat[1:0] = MODE_HBLANK;
          end
          stat[STAT_BUSY_BIT] = 1'b1;
          model_stat = stat;
        end
      end
      KIND_WRITE: begin
        case (it.reg_sel)
          REG_LCDC: model_lcdc = it.write_data;
          // Only the interrupt enables are writable. The busy bit comes up set.
          REG_STAT: model_stat = {1'b1, it.write_data[6:3], model_stat[2:0]};
          REG_LY:   ;
          REG_LYC:  model_lyc = it.write_data;
          default:  ;
        endcase
      end
      KIND_READ: begin
        case (it.reg_sel)
          REG_LCDC: r.read_data = model_lcdc;
          REG_STAT: r.read_data = model_stat;
          REG_LY:   r.read_data = model_ly;
          REG_LYC:  r.read_data = model_lyc;
          default:  r.read_data = 8'd0;
        endcase
      end
      default: ;
    endcase
    if (irq) irqs_raised++;
    r.stat_interrupt = irq;
    r.oam_locked     = model_oam_lock;
    r.vram_locked    = model_vram_lock;
    r.line_number    = model_ly;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Expected results, oldest first. Each accepted input transaction pushes
  // one entry, and each accepted result transaction pops one.
  // --------------------------------------------------------------------------
  result_t expected_results[$];
  int      failures;
  int      results_checked;

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction arrived with nothing expected");
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, result.read_data);
          failures++;
        end
        if (result.stat_interrupt !== want.stat_interrupt) begin
          $error("stat_interrupt: expected %0b, got %0b",
                 want.stat_interrupt, result.stat_interrupt);
          failures++;
        end
        if (result.oam_locked !== want.oam_locked) begin
          $error("oam_locked: expected %0b, got %0b", want.oam_locked, result.oam_locked);
          failures++;
        end
        if (result.vram_locked !== want.vram_locked) begin
          $error("vram_locked: expected %0b, got %0b", want.vram_locked, result.vram_locked);
          failures++;
        end
        if (result.line_number !== want.line_number) begin
          $error("line_number: expected %0d, got %0d", want.line_number, result.line_number);
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. A hung handshake ends the run. The counter clears on any
  // transaction on either channel, so only a true stall can reach the limit.
  // --------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $error("no transaction on either channel for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side. The receiver drops ready at the phase's rate. Once, at the
  // start of the last phase, it holds ready low for a long stretch. The sender
  // keeps offering during that stretch, so the block's pipeline fills and it
  // has to push back on its input.
  // --------------------------------------------------------------------------
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_off_req;
  bit hold_off_served;

  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_served) begin
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_served = 1'b1;
      end
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Item side. The sender may idle before a transaction. After that it holds
  // valid and the payload until the block accepts the transaction, and then
  // it records the expectation. A typed row supplies its own expected result,
  // but the model still runs so that its state keeps pace with the block.
  // --------------------------------------------------------------------------
  int items_sent;

  task automatic offer_item(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predicted = next_display_result(it);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Random traffic is mostly ticks, so the line counter sweeps whole frames.
  // LCDC writes are rare and nearly always keep the display on, so frames
  // seldom restart. The other kinds fill the gaps.
  function automatic item_t random_display_item();
    item_t it;
    int    pick;
    it.mode       = 2'($urandom_range(3));
    it.reg_sel    = 2'($urandom_range(3));
    it.write_data = 8'($urandom_range(255));
    it.cycles     = 9'($urandom_range(511));
    pick          = $urandom_range(99);
    if (pick < 60) begin
      it.mode = KIND_TICK;
      if ($urandom_range(1)) it.cycles = 9'($urandom_range(455, 200));
      else if ($urandom_range(9) == 0) it.cycles = 9'($urandom_range(511, 456));
      else it.cycles = 9'($urandom_range(199));
    end else if (pick < 62) begin
      it.mode    = KIND_WRITE;
      it.reg_sel = REG_LCDC;
      if ($urandom_range(15) != 0) it.write_data[LCDC_ENABLE_BIT] = 1'b1;
    end else if (pick < 72) begin
      it.mode    = KIND_WRITE;
      it.reg_sel = REG_STAT;
    end else if (pick < 79) begin
      it.mode    = KIND_WRITE;
      it.reg_sel = REG_LYC;
      // Most compares target a line that actually occurs.
      if ($urandom_range(3) != 0) it.write_data = 8'($urandom_range(LAST_LINE));
    end else if (pick < 81) begin
      it.mode    = KIND_WRITE;
      it.reg_sel = REG_LY;
    end else if (pick < 98) begin
      it.mode = KIND_READ;
    end else begin
      it.mode = KIND_UNUSED;
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table. The first rows run before the display is ever enabled,
  // so their results can be written out by hand. The rows after the enable
  // go through the model, but for the LCDC read that checks it.
  // --------------------------------------------------------------------------
  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic void add_row(input logic [1:0] kind, input logic [1:0] sel,
                                  input logic [7:0] data, input logic [8:0] cyc,
                                  input bit typed, input result_t want);
    directed_row_t row;
    row.stim  = {kind, sel, data, cyc};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  initial begin
    item_t it;
    int    phase;
    int    counted;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;

    model_dots      = '0;
    model_ly        = '0;
    model_lyc       = '0;
    model_lcdc      = '0;
    model_stat      = '0;
    model_oam_lock  = 1'b0;
    model_vram_lock = 1'b0;

    // Every register reads zero out of reset, STAT included.
    add_row(KIND_READ,   REG_LCDC, 8'h00, 9'd0,   TYPED, QUIET);
    add_row(KIND_READ,   REG_STAT, 8'h00, 9'd0,   TYPED, QUIET);
    add_row(KIND_READ,   REG_LY,   8'h00, 9'd0,   TYPED, QUIET);
    add_row(KIND_READ,   REG_LYC,  8'h00, 9'd0,   TYPED, QUIET);
    // A tick with the display off only sets the STAT busy bit.
    add_row(KIND_TICK,   REG_LCDC, 8'h00, 9'd100, TYPED, QUIET);
    add_row(KIND_READ,   REG_STAT, 8'h00, 9'd0,   TYPED, {8'h80, 3'b000, 8'd0});
    // LY is read-only.
    add_row(KIND_WRITE,  REG_LY,   8'hFF, 9'd0,   TYPED, QUIET);
    add_row(KIND_READ,   REG_LY,   8'h00, 9'd0,   TYPED, QUIET);
    // A STAT write keeps only the enables. The coincidence and mode bits
    // remain as they were.
    add_row(KIND_WRITE,  REG_STAT, 8'hFF, 9'd0,   TYPED, QUIET);
    add_row(KIND_READ,   REG_STAT, 8'h00, 9'd0,   TYPED, {8'hF8, 3'b000, 8'd0});
    add_row(KIND_WRITE,  REG_LYC,  8'h01, 9'd0,   TYPED, QUIET);
    add_row(KIND_READ,   REG_LYC,  8'h00, 9'd0,   TYPED, {8'h01, 3'b000, 8'd0});
    // The unused kind, with every field at its maximum, changes nothing.
    add_row(KIND_UNUSED, REG_LYC,  8'hFF, 9'h1FF, TYPED, QUIET);
    add_row(KIND_WRITE,  REG_LCDC, 8'h80, 9'd0,   TYPED, QUIET);
    add_row(KIND_READ,   REG_LCDC, 8'h00, 9'd0,   TYPED, {8'h80, 3'b000, 8'd0});
    // Display on with all enables set. The OAM entry interrupts. An oversized
    // tick saturates into HBlank. A one-dot tick then wraps to line 1, which
    // matches LYC. The transfer mode follows.
    add_row(KIND_TICK,   REG_LCDC, 8'h00, 9'd0,   PREDICTED, QUIET);
    add_row(KIND_TICK,   REG_LCDC, 8'h00, 9'h1FF, PREDICTED, QUIET);
    add_row(KIND_TICK,   REG_LCDC, 8'h00, 9'd1,   PREDICTED, QUIET);
    add_row(KIND_TICK,   REG_LCDC, 8'h00, 9'd100, PREDICTED, QUIET);
    add_row(KIND_READ,   REG_STAT, 8'h00, 9'd0,   PREDICTED, QUIET);
    add_row(KIND_WRITE,  REG_STAT, 8'h00, 9'd0,   PREDICTED, QUIET);
    add_row(KIND_TICK,   REG_LCDC, 8'h00, 9'd455, PREDICTED, QUIET);
    // Turning the display off mid-line keeps whichever locks are held.
    add_row(KIND_WRITE,  REG_LCDC, 8'h00, 9'd0,   PREDICTED, QUIET);
    add_row(KIND_TICK,   REG_LCDC, 8'h00, 9'd300, PREDICTED, QUIET);
    add_row(KIND_WRITE,  REG_LCDC, 8'h91, 9'd0,   PREDICTED, QUIET);

    tx_idle_pct = 33;
    rx_idle_pct = 88;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    // Three idling phases: the receiver slow, then the sender slow, then both
    // at full rate. The long result hold-off opens the last phase.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 88;
        end
        1: begin
          tx_idle_pct = 88;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_idle_pct  = 0;
          hold_off_req = 1'b1;
        end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_display_item();
        offer_item(it, PREDICTED, QUIET);
        // LY writes and the unused kind leave the block untouched.
        if (!(it.mode == KIND_UNUSED || (it.mode == KIND_WRITE && it.reg_sel == REG_LY)))
          counted++;
      end
    end
    item_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions and checked %0d results; %0d ticks, %0d display-off ticks.",
             items_sent, results_checked, ticks_run, display_offs);
    $display("Swept %0d line wraps over %0d full frames; %0d STAT interrupts were expected.",
             lines_wrapped, frames_done, irqs_raised);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
